/* design/battery_cell_detect_and_monitor_core_assert.svh */
// Assertion macros shared by the battery cell detect and monitor RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef BATTERY_CELL_DETECT_AND_MONITOR_CORE_ASSERT_SVH
`define BATTERY_CELL_DETECT_AND_MONITOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BCDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BCDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    `BCDM_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define BCDM_ASSERT(lbl, prop, msg)
`define BCDM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/bcdm_pkg.sv */
// Package for the battery cell detect and monitor core.
// Holds widths, constants, controller states and the command/status types.
// No dependencies.
package bcdm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int GAIN_W     = 16;
    localparam int WIN_W      = 12;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MV_W       = 16;
    localparam int PERMILLE_W = 10;
    localparam int CELLS_W    = 3;
    localparam int COUNT_W    = 13;
    localparam int RUN_W      = 8;
    localparam int DIV_NUM_W  = 28;
    localparam int DIV_DEN_W  = 13;

    localparam int DETECT_SAMPLES_MINUS_ONE_DEF = 20;
    localparam int LOW_HOLD_REPORTS_DEF         = 40;

    localparam logic [GAIN_W-1:0] ADC_GAIN_UV_RESET  = 16'd9036;
    localparam logic [WIN_W-1:0]  WINDOW_COUNT_RESET = 12'd400;

    localparam logic [CFG_IDX_W-1:0] CFG_ADC_GAIN_UV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 2'd1;

    localparam logic [DIV_DEN_W-1:0]  UV_PER_MV      = 13'd1000;
    localparam logic [DIV_NUM_W-1:0]  PERMILLE_SCALE = 28'd1000;
    localparam logic [PERMILLE_W-1:0] CHARGE_MAX     = 10'd990;
    localparam logic [PERMILLE_W-1:0] CHARGE_LOW_4S  = 10'd600;
    localparam logic [PERMILLE_W-1:0] CHARGE_LOW     = 10'd30;

    localparam logic [MV_W-1:0] DET_3S_LO = 16'd10100;
    localparam logic [MV_W-1:0] DET_3S_HI = 16'd13600;
    localparam logic [MV_W-1:0] DET_4S_LO = 16'd13800;
    localparam logic [MV_W-1:0] DET_4S_HI = 16'd17400;

    localparam logic [CELLS_W-1:0] CELLS_2S = 3'd2;
    localparam logic [CELLS_W-1:0] CELLS_3S = 3'd3;
    localparam logic [CELLS_W-1:0] CELLS_4S = 3'd4;

    localparam int EMPTY_MV_PER_CELL = 3120;
    localparam int SPAN_MV_PER_CELL  = 1130;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SCALE_START,
        S_SCALE_WAIT,
        S_CHECK,
        S_AVG_START,
        S_AVG_WAIT,
        S_CHG_START,
        S_CHG_WAIT,
        S_LOW_UPD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DIV_SCALE,
        DIV_AVG,
        DIV_CHARGE
    } t_div_sel;

    typedef struct packed {
        logic     load_sample;
        logic     mul;
        logic     div_start;
        t_div_sel div_sel;
        logic     accum;
        logic     detect_commit;
        logic     avg_commit;
        logic     charge_commit;
        logic     low_update;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sample_zero;
        logic div_done;
        logic window_hit;
        logic monitor;
        logic avg_le_empty;
        logic out_free;
    } t_dp_status;

    function automatic logic [MV_W-1:0] empty_mv(input logic [CELLS_W-1:0] cells);
        return MV_W'(EMPTY_MV_PER_CELL * int'(cells));
    endfunction

    function automatic logic [DIV_DEN_W-1:0] span_mv(input logic [CELLS_W-1:0] cells);
        return DIV_DEN_W'(SPAN_MV_PER_CELL * int'(cells));
    endfunction

endpackage

/* design/bcdm_div.sv */
// Iterative unsigned divider, two quotient bits per cycle.
// Depends on bcdm_pkg and the assertion macro header.
`include "battery_cell_detect_and_monitor_core_assert.svh"
module bcdm_div
    import bcdm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_dividend,
    input  logic [DIV_DEN_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quotient
);

    localparam int BitsPerCycle = 2;
    localparam int Steps        = DIV_NUM_W / BitsPerCycle;
    localparam int CntW         = $clog2(Steps);

    logic                 r_busy;
    logic                 r_done;
    logic [CntW-1:0]      r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] n_quo;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        logic [DIV_DEN_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int i = 0; i < BitsPerCycle; i++) begin
            trial = {n_rem, n_quo[DIV_NUM_W-1]};
            n_quo = {n_quo[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem    = DIV_DEN_W'(trial - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[DIV_DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(Steps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `BCDM_ASSERT(a_done_idle, r_done |-> !r_busy, "Divider signals done while still busy.")
    `BCDM_ASSERT_NEXT(a_start_busy, i_start, r_busy, "Divider did not start after a request.")

endmodule

/* design/bcdm_datapath.sv */
// Datapath: configuration registers, scaling, accumulation, averaging,
// charge estimate, low-battery tracking and the output register.
// Depends on bcdm_pkg, bcdm_div and the assertion macro header.
`include "battery_cell_detect_and_monitor_core_assert.svh"
module bcdm_datapath
    import bcdm_pkg::*;
#(
    parameter int unsigned DETECT_SAMPLES_MINUS_ONE = DETECT_SAMPLES_MINUS_ONE_DEF,
    parameter int unsigned LOW_HOLD_REPORTS         = LOW_HOLD_REPORTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [SAMPLE_W-1:0]   i_adc_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_report_valid,
    output logic [CELLS_W-1:0]    o_cells_detected,
    output logic [MV_W-1:0]       o_average_mv,
    output logic [PERMILLE_W-1:0] o_charge_permille,
    output logic                  o_low_battery
);

    localparam logic [COUNT_W-1:0] DetThr = COUNT_W'(DETECT_SAMPLES_MINUS_ONE);
    localparam logic [RUN_W-1:0]   LowThr = RUN_W'(LOW_HOLD_REPORTS);

    logic [GAIN_W-1:0]     r_gain;
    logic [WIN_W-1:0]      r_window;
    logic [SAMPLE_W-1:0]   r_sample;
    logic [DIV_NUM_W-1:0]  r_product;
    logic [DIV_NUM_W-1:0]  r_chg_num;
    logic [DIV_NUM_W-1:0]  r_sum;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_phase;
    logic [CELLS_W-1:0]    r_cells;
    logic [MV_W-1:0]       r_avg;
    logic [PERMILLE_W-1:0] r_permille;
    logic [RUN_W-1:0]      r_run;
    logic                  r_low;
    logic                  r_report;
    logic                  r_out_valid;
    logic                  r_o_report;
    logic [CELLS_W-1:0]    r_o_cells;
    logic [MV_W-1:0]       r_o_avg;
    logic [PERMILLE_W-1:0] r_o_permille;
    logic                  r_o_low;

    logic                  div_done;
    logic [DIV_NUM_W-1:0]  div_q;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    logic [MV_W-1:0]       q_sat;
    logic [MV_W-1:0]       empty;
    logic [MV_W-1:0]       avg_diff;
    logic [CELLS_W-1:0]    cells_pick;
    logic [PERMILLE_W-1:0] permille_clamp;
    logic [RUN_W-1:0]      n_run;
    logic                  n_low;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_AVG: begin
                div_num = r_sum;
                div_den = r_count;
            end
            DIV_CHARGE: begin
                div_num = r_chg_num;
                div_den = span_mv(r_cells);
            end
            default: begin
                div_num = r_product;
                div_den = UV_PER_MV;
            end
        endcase
    end

    bcdm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign q_sat    = (|div_q[DIV_NUM_W-1:MV_W]) ? '1 : div_q[MV_W-1:0];
    assign empty    = empty_mv(r_cells);
    assign avg_diff = q_sat - empty;

    always_comb begin
        if (q_sat > DET_3S_LO && q_sat < DET_3S_HI) begin
            cells_pick = CELLS_3S;
        end else if (q_sat > DET_4S_LO && q_sat < DET_4S_HI) begin
            cells_pick = CELLS_4S;
        end else begin
            cells_pick = CELLS_2S;
        end
    end

    assign permille_clamp = (div_q > DIV_NUM_W'(CHARGE_MAX)) ? CHARGE_MAX
                                                             : div_q[PERMILLE_W-1:0];

    always_comb begin
        n_run = r_run;
        n_low = r_permille < CHARGE_LOW;
        if (r_cells == CELLS_4S) begin
            if (r_permille < CHARGE_LOW_4S) begin
                n_run = (r_run == '1) ? r_run : r_run + 1'b1;
            end else begin
                n_run = '0;
            end
            n_low = n_run > LowThr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= ADC_GAIN_UV_RESET;
            r_window    <= WINDOW_COUNT_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_phase     <= 1'b0;
            r_cells     <= '0;
            r_avg       <= '0;
            r_permille  <= '0;
            r_run       <= '0;
            r_low       <= 1'b0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ADC_GAIN_UV:  r_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_WINDOW_COUNT: r_window <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_sample) begin
                r_report <= 1'b0;
            end
            if (i_cmd.accum) begin
                r_sum   <= r_sum + DIV_NUM_W'(q_sat);
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.detect_commit) begin
                r_cells <= cells_pick;
                r_sum   <= '0;
                r_count <= '0;
                r_phase <= 1'b1;
            end
            if (i_cmd.avg_commit) begin
                r_avg      <= q_sat;
                r_permille <= '0;
                r_sum      <= '0;
                r_count    <= '0;
            end
            if (i_cmd.charge_commit) begin
                r_permille <= permille_clamp;
            end
            if (i_cmd.low_update) begin
                r_run    <= n_run;
                r_low    <= n_low;
                r_report <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_adc_sample;
        end
        if (i_cmd.mul) begin
            r_product <= DIV_NUM_W'(r_sample) * DIV_NUM_W'(r_gain);
        end
        if (i_cmd.avg_commit) begin
            r_chg_num <= DIV_NUM_W'(avg_diff) * PERMILLE_SCALE;
        end
        if (i_cmd.out_load) begin
            r_o_report   <= r_report;
            r_o_cells    <= r_cells;
            r_o_avg      <= r_avg;
            r_o_permille <= r_permille;
            r_o_low      <= r_low;
        end
    end

    assign o_status.sample_zero  = (r_sample == '0);
    assign o_status.div_done     = div_done;
    assign o_status.window_hit   = r_phase ? (r_count > {1'b0, r_window} && r_count != '0)
                                           : (r_count > DetThr);
    assign o_status.monitor      = r_phase;
    assign o_status.avg_le_empty = (q_sat <= empty);
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_report_valid    = r_o_report;
    assign o_cells_detected  = r_o_cells;
    assign o_average_mv      = r_o_avg;
    assign o_charge_permille = r_o_permille;
    assign o_low_battery     = r_o_low;

    `BCDM_ASSERT(a_cells_known, r_phase |-> (r_cells == CELLS_2S || r_cells == CELLS_3S || r_cells == CELLS_4S), "Monitor phase without a valid cell count.")
    `BCDM_ASSERT(a_detect_count, !r_phase |-> (r_count <= DetThr + 1'b1), "Detect count ran past its limit.")

endmodule

/* design/bcdm_ctrl.sv */
// Controller state machine that sequences the datapath for one beat.
// Depends on bcdm_pkg and the assertion macro header.
`include "battery_cell_detect_and_monitor_core_assert.svh"
module bcdm_ctrl
    import bcdm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = i_status.sample_zero ? S_CHECK : S_SCALE_START;
            end
            S_SCALE_START: n_state = S_SCALE_WAIT;
            S_SCALE_WAIT: begin
                if (i_status.div_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_status.window_hit ? S_AVG_START : S_DONE;
            end
            S_AVG_START: n_state = S_AVG_WAIT;
            S_AVG_WAIT: begin
                if (i_status.div_done) begin
                    if (!i_status.monitor) begin
                        n_state = S_DONE;
                    end else if (i_status.avg_le_empty) begin
                        n_state = S_LOW_UPD;
                    end else begin
                        n_state = S_CHG_START;
                    end
                end
            end
            S_CHG_START: n_state = S_CHG_WAIT;
            S_CHG_WAIT: begin
                if (i_status.div_done) n_state = S_LOW_UPD;
            end
            S_LOW_UPD: n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_SCALE;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_sample = i_in_valid;
            end
            S_MUL: o_cmd.mul = 1'b1;
            S_SCALE_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SCALE;
            end
            S_SCALE_WAIT: o_cmd.accum = i_status.div_done;
            S_AVG_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_AVG;
            end
            S_AVG_WAIT: begin
                o_cmd.detect_commit = i_status.div_done && !i_status.monitor;
                o_cmd.avg_commit    = i_status.div_done && i_status.monitor;
            end
            S_CHG_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_CHARGE;
            end
            S_CHG_WAIT: o_cmd.charge_commit = i_status.div_done;
            S_LOW_UPD: o_cmd.low_update = 1'b1;
            S_DONE: o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

    `BCDM_ASSERT(a_load_free, o_cmd.out_load |-> i_status.out_free, "Output register loaded while still full.")
    `BCDM_ASSERT_NEXT(a_accept_mul, i_in_valid && o_in_ready, r_state == S_MUL, "Accepted beat did not start processing.")

endmodule

/* design/battery_cell_detect_and_monitor_core.sv */
// Top level of the battery cell detect and monitor core.
// Depends on bcdm_pkg, bcdm_ctrl and bcdm_datapath.
//
// Each beat carries one raw 12-bit battery sample and yields exactly one
// result beat. The block works on one sample at a time and takes a new one
// once the previous result is in the output register. All work runs through
// one shared divider that resolves two quotient bits per cycle. A zero
// sample, or a window whose average is at or below the empty voltage, skips
// one division. A result that waits on the output holds off the next sample.
// Configuration is written on a plain write port and must only change while
// the block is idle.
module battery_cell_detect_and_monitor_core
    import bcdm_pkg::*;
#(
    parameter int unsigned DETECT_SAMPLES_MINUS_ONE = DETECT_SAMPLES_MINUS_ONE_DEF,
    parameter int unsigned LOW_HOLD_REPORTS         = LOW_HOLD_REPORTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_adc_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_report_valid,
    output logic [CELLS_W-1:0]    o_cells_detected,
    output logic [MV_W-1:0]       o_average_mv,
    output logic [PERMILLE_W-1:0] o_charge_permille,
    output logic                  o_low_battery,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    bcdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    bcdm_datapath #(
        .DETECT_SAMPLES_MINUS_ONE (DETECT_SAMPLES_MINUS_ONE),
        .LOW_HOLD_REPORTS         (LOW_HOLD_REPORTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_adc_sample      (i_adc_sample),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_report_valid    (o_report_valid),
        .o_cells_detected  (o_cells_detected),
        .o_average_mv      (o_average_mv),
        .o_charge_permille (o_charge_permille),
        .o_low_battery     (o_low_battery)
    );

endmodule
